/* rtl/smrf_pkg.sv */
// ----------------------------------------------------------------------------
// smrf_pkg: shared types and constants of the sliding median range filter
// Window geometry, status codes, register indexes and the cell control word.
// ----------------------------------------------------------------------------
package smrf_pkg;

  // Window geometry; legal sizes run from 3 to 15.
  localparam int WINDOW_SIZE = 5;
  localparam int IDX_W       = $clog2(WINDOW_SIZE);
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
  localparam int MED_RANK    = WINDOW_SIZE / 2;

  // Field widths.
  localparam int DATA_W      = 16;
  localparam int CFG_ADDR_W  = 8;

  // Reset values of the configuration registers.
  localparam logic [DATA_W-1:0] REJECT_ABOVE_RST = DATA_W'(1000);
  localparam logic [DATA_W-1:0] VALID_LIMIT_RST  = DATA_W'(35);

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_REJECT_ABOVE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_VALID_LIMIT  = CFG_ADDR_W'(1);

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_NONE    = 3'd0,
    STAT_REJECT  = 3'd1,
    STAT_FILLING = 3'd2,
    STAT_IN      = 3'd3,
    STAT_OUT     = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RANK,
    SEQ_FINISH
  } seq_state_t;

  // Control word broadcast to every cell of the row.
  typedef struct packed {
    logic shift;  // move the window one cell along, new sample into cell 0
    logic load;   // start a ranking pass from the (shifted) window contents
    logic step;   // rotate the circulating values and count one comparison
  } cell_ctrl_t;

endpackage

/* rtl/smrf_in_if.sv */
// ----------------------------------------------------------------------------
// smrf_in_if: sample input channel
// Valid/ready channel carrying one distance reading and its presence flag.
// ----------------------------------------------------------------------------
interface smrf_in_if;
  logic                 valid;
  logic                 ready;
  logic                 read_ok;
  smrf_pkg::data_t      distance_sample;

  modport source (output valid, output read_ok, output distance_sample, input ready);
  modport sink   (input valid, input read_ok, input distance_sample, output ready);
endinterface

/* rtl/smrf_out_if.sv */
// ----------------------------------------------------------------------------
// smrf_out_if: result output channel
// Valid/ready channel carrying the status code and the window median.
// ----------------------------------------------------------------------------
interface smrf_out_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  smrf_pkg::data_t      median_value;

  modport source (output valid, output status, output median_value, input ready);
  modport sink   (input valid, input status, input median_value, output ready);
endinterface

/* rtl/smrf_cfg_if.sv */
// ----------------------------------------------------------------------------
// smrf_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and the data to write.
// ----------------------------------------------------------------------------
interface smrf_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [smrf_pkg::CFG_ADDR_W-1:0]      addr;
  smrf_pkg::data_t                      wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

/* rtl/sliding_median_range_filter.sv */
// ----------------------------------------------------------------------------
// sliding_median_range_filter: running median of ultrasonic range readings
// Rejects out-of-range readings and reports the median of the last accepted
// readings together with an in-range verdict.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   beats carry read_ok and distance_sample. A beat without a reading
//           yields status 0, a reading of zero or above reject_above yields
//           status 1, and neither touches the window.
//   out_ch  beats carry status and median_value; exactly one per input beat,
//           in order. median_value is zero unless status is 3 or 4.
//   cfg_ch  writes reject_above (index 0) or valid_limit (index 1); other
//           indexes are ignored. cfg_ch is always ready; write while idle.
// Timing: beats that need no median are answered in the cycle after
//   acceptance. Once the window is full, an accepted reading runs
//   WINDOW_SIZE-1 rotation steps of the cell ring and then a select state
//   that loads the result into the output register as soon as that is free.
//   The next beat is taken only after that; one item is in flight at a time.
// Reset: rst_n (synchronous, active low) empties the window by clearing the
//   fill count, clears the output valid flag, and restores the register defaults.
// Stalls: the result waits in the output register while out_ch.ready is low;
//   in_ch.ready is low while a median is being ranked and whenever the output
//   register holds a result that out_ch does not take in the same cycle.
// ----------------------------------------------------------------------------
module sliding_median_range_filter (
  input  logic        clk,
  input  logic        rst_n,
  smrf_in_if.sink     in_ch,
  smrf_out_if.source  out_ch,
  smrf_cfg_if.sink    cfg_ch
);

  localparam int W = smrf_pkg::WINDOW_SIZE;

  // Configuration registers.
  smrf_pkg::data_t reject_above_r, reject_above_nxt;
  smrf_pkg::data_t valid_limit_r, valid_limit_nxt;

  // Sequencer and window bookkeeping.
  smrf_pkg::seq_state_t state_r, state_nxt;
  smrf_pkg::cnt_t       fill_r, fill_nxt, fill_inc;
  smrf_pkg::idx_t       step_r, step_nxt;
  smrf_pkg::cell_ctrl_t ctrl;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  smrf_pkg::status_t    out_status_r, out_status_nxt;
  smrf_pkg::data_t      out_median_r, out_median_nxt;

  // Cell row signals.
  smrf_pkg::data_t cell_value [W];
  smrf_pkg::data_t cell_circ [W];
  smrf_pkg::idx_t  cell_circ_idx [W];
  logic            cell_is_med [W];
  smrf_pkg::data_t median;

  logic in_fire;
  logic out_free;
  logic full;
  logic reject;

  // Configuration writes; the port never stalls.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    reject_above_nxt = reject_above_r;
    valid_limit_nxt  = valid_limit_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        smrf_pkg::CFG_REJECT_ABOVE: reject_above_nxt = cfg_ch.wdata;
        smrf_pkg::CFG_VALID_LIMIT:  valid_limit_nxt  = cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reject_above_r <= smrf_pkg::REJECT_ABOVE_RST;
      valid_limit_r  <= smrf_pkg::VALID_LIMIT_RST;
    end else begin
      reject_above_r <= reject_above_nxt;
      valid_limit_r  <= valid_limit_nxt;
    end
  end

  // Ring of window cells: cell 0 takes the new sample, each cell shifts into
  // the next, and the circulating values move from cell i-1 to cell i.
  for (genvar i = 0; i < W; i++) begin : g_cell
    smrf_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .cell_idx      (smrf_pkg::idx_t'(i)),
      .shift_in      ((i == 0) ? in_ch.distance_sample : cell_value[(i + W - 1) % W]),
      .left_circ     (cell_circ[(i + W - 1) % W]),
      .left_circ_idx (cell_circ_idx[(i + W - 1) % W]),
      .value_o       (cell_value[i]),
      .circ_o        (cell_circ[i]),
      .circ_idx_o    (cell_circ_idx[i]),
      .is_median_o   (cell_is_med[i])
    );
  end

  // Exactly one cell holds the middle rank after a full pass.
  always_comb begin
    median = '0;
    for (int i = 0; i < W; i++) begin
      if (cell_is_med[i]) begin
        median = median | cell_value[i];
      end
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == smrf_pkg::SEQ_IDLE) && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign full = (fill_r == smrf_pkg::cnt_t'(W));
  assign fill_inc = full ? fill_r : fill_r + smrf_pkg::cnt_t'(1);
  assign reject = (in_ch.distance_sample == '0) ||
                  (in_ch.distance_sample > reject_above_r);

  // Sequencer: next state, cell control and output register loading.
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    step_nxt       = step_r;
    ctrl           = '0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_median_nxt = out_median_r;
    case (state_r)
      smrf_pkg::SEQ_IDLE: begin
        if (in_fire) begin
          if (!in_ch.read_ok) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = smrf_pkg::STAT_NONE;
            out_median_nxt = '0;
          end else if (reject) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = smrf_pkg::STAT_REJECT;
            out_median_nxt = '0;
          end else begin
            ctrl.shift = 1'b1;
            fill_nxt   = fill_inc;
            if (fill_inc == smrf_pkg::cnt_t'(W)) begin
              ctrl.load = 1'b1;
              step_nxt  = '0;
              state_nxt = smrf_pkg::SEQ_RANK;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = smrf_pkg::STAT_FILLING;
              out_median_nxt = '0;
            end
          end
        end
      end
      smrf_pkg::SEQ_RANK: begin
        ctrl.step = 1'b1;
        step_nxt  = step_r + smrf_pkg::idx_t'(1);
        if (step_r == smrf_pkg::idx_t'(W - 2)) begin
          state_nxt = smrf_pkg::SEQ_FINISH;
        end
      end
      smrf_pkg::SEQ_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = (median <= valid_limit_r) ? smrf_pkg::STAT_IN
                                                     : smrf_pkg::STAT_OUT;
          out_median_nxt = median;
          state_nxt      = smrf_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = smrf_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smrf_pkg::SEQ_IDLE;
      fill_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_median_r <= out_median_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.median_value = out_median_r;

endmodule

/* rtl/smrf_cell.sv */
// ----------------------------------------------------------------------------
// smrf_cell: one window cell of the median ranking ring
// Holds one window entry, passes it to the next cell on a shift, and counts
// how many entries rank below it while the values circulate around the ring.
// ----------------------------------------------------------------------------
module smrf_cell (
  input  logic                 clk,
  input  smrf_pkg::cell_ctrl_t ctrl,
  input  smrf_pkg::idx_t       cell_idx,
  input  smrf_pkg::data_t      shift_in,
  input  smrf_pkg::data_t      left_circ,
  input  smrf_pkg::idx_t       left_circ_idx,
  output smrf_pkg::data_t      value_o,
  output smrf_pkg::data_t      circ_o,
  output smrf_pkg::idx_t       circ_idx_o,
  output logic                 is_median_o
);

  smrf_pkg::data_t value_r, value_nxt;
  smrf_pkg::data_t circ_r, circ_nxt;
  smrf_pkg::idx_t  circ_idx_r, circ_idx_nxt;
  smrf_pkg::idx_t  rank_r, rank_nxt;
  logic            below;

  // A passing entry ranks below this one if it is smaller, or equal and
  // from a lower cell, so every entry gets a distinct rank.
  assign below = (left_circ < value_r) ||
                 ((left_circ == value_r) && (left_circ_idx < cell_idx));

  always_comb begin
    value_nxt    = value_r;
    circ_nxt     = circ_r;
    circ_idx_nxt = circ_idx_r;
    rank_nxt     = rank_r;
    if (ctrl.shift) begin
      value_nxt = shift_in;
    end
    if (ctrl.load) begin
      circ_nxt     = value_nxt;
      circ_idx_nxt = cell_idx;
      rank_nxt     = '0;
    end else if (ctrl.step) begin
      circ_nxt     = left_circ;
      circ_idx_nxt = left_circ_idx;
      if (below) begin
        rank_nxt = rank_r + smrf_pkg::idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    circ_r     <= circ_nxt;
    circ_idx_r <= circ_idx_nxt;
    rank_r     <= rank_nxt;
  end

  assign value_o     = value_r;
  assign circ_o      = circ_r;
  assign circ_idx_o  = circ_idx_r;
  assign is_median_o = (rank_r == smrf_pkg::idx_t'(smrf_pkg::MED_RANK));

endmodule
